FILE: hw/rtl/ectc_pkg.sv
// Shared types and constants for the elapsed / count-down time counter.
// Holds the reciprocal constants for division by fixed time units.
// No dependencies.
package ectc_pkg;

	localparam int unsigned MS_PER_SEC      = 1000;
	localparam int unsigned HALF_SEC_MS     = 500;
	localparam int unsigned SECS_PER_MIN    = 60;
	localparam int unsigned MIN_PER_HOUR    = 60;
	localparam int unsigned HOURS_PER_DAY   = 24;
	localparam int unsigned DAYS_PER_YEAR   = 365;
	localparam int unsigned SECS_PER_HOUR   = 3600;
	localparam int unsigned SECS_PER_DAY    = 86400;
	localparam int unsigned SECS_PER_YEAR   = 31536000;

	localparam int unsigned TARGET_W = 42;

	// x / d == (x * ceil(2^k / d)) >> k for every 32-bit x, with k = 32 + ceil(log2 d)
	localparam logic [5:0] SH_MS   = 6'd42;
	localparam logic [5:0] SH_MIN  = 6'd38;
	localparam logic [5:0] SH_HOUR = 6'd44;
	localparam logic [5:0] SH_DAY  = 6'd49;
	localparam logic [5:0] SH_YEAR = 6'd57;

	localparam logic [32:0] REC_MS   =
		33'(((64'd1 << SH_MS) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC));
	localparam logic [32:0] REC_MIN  =
		33'(((64'd1 << SH_MIN) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));
	localparam logic [32:0] REC_HOUR =
		33'(((64'd1 << SH_HOUR) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));
	localparam logic [32:0] REC_DAY  =
		33'(((64'd1 << SH_DAY) + 64'(SECS_PER_DAY) - 64'd1) / 64'(SECS_PER_DAY));
	localparam logic [32:0] REC_YEAR =
		33'(((64'd1 << SH_YEAR) + 64'(SECS_PER_YEAR) - 64'd1) / 64'(SECS_PER_YEAR));

	localparam logic [4:0] DAY_ARM_HOUR     = 5'd13;
	localparam logic [3:0] MONTH_LAST       = 4'd11;
	localparam logic [8:0] SHORT_MONTH_DAYS = 9'd30;
	localparam logic [8:0] LONG_MONTH_DAYS  = 9'd31;

	typedef enum logic [0:0] {
		REG_COUNT_MODE        = 1'b0,
		REG_COUNTDOWN_SECONDS = 1'b1
	} reg_index_t;

	typedef enum logic [0:0] {
		MODE_UP   = 1'b0,
		MODE_DOWN = 1'b1
	} count_mode_t;

	typedef struct packed {
		count_mode_t         mode;
		logic [31:0]         cd_secs;
		logic [TARGET_W-1:0] target_ms;
	} cfg_t;

	typedef struct packed {
		logic        restart;
		logic [31:0] elapsed;
		logic [31:0] q_ms;
		logic [31:0] carried;
	} stamp_t;

	typedef struct packed {
		logic        restart;
		logic        hit;
		logic [31:0] secs;
		logic [31:0] q_min;
		logic [31:0] q_hour;
		logic [31:0] q_day;
		logic [7:0]  q_year;
		logic [31:0] elapsed;
	} split_t;

	typedef struct packed {
		logic [5:0]  sec_field;
		logic [5:0]  min_field;
		logic [4:0]  hour_field;
		logic [8:0]  day_field;
		logic [3:0]  month_field;
		logic [7:0]  year_field;
		logic [15:0] whole_days;
		logic [31:0] elapsed_ms;
		logic        done_flag;
	} result_t;

	function automatic logic [31:0] recip_div(input logic [31:0] x, input logic [32:0] m,
		input logic [5:0] sh);
		logic [64:0] p;
		p = {33'd0, x} * {32'd0, m};
		return 32'(p >> sh);
	endfunction

endpackage

FILE: hw/rtl/ectc_stamp.sv
// Timestamp stage: start/last stamps, carried seconds and the per-item ms-to-second step.
// Depends on ectc_pkg.
module ectc_stamp (
	input  logic            clk,
	input  logic            arst_n,
	input  ectc_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [31:0]     in_now,
	input  logic            in_restart,
	output logic            out_valid,
	input  logic            out_ready,
	output ectc_pkg::stamp_t out_item
);
	import ectc_pkg::*;

	logic        started_q;
	logic [31:0] start_q, last_q, total_q, carried_q;
	logic        valid_s2;
	stamp_t      item_s2;

	logic        e_started;
	logic [31:0] e_start, e_last, e_total, e_carried;
	logic        wrap, keep;
	logic [31:0] st0, n_start, n_carried, n_last, n_total, base, elapsed, q_ms;
	logic        load;

	assign in_ready  = !valid_s2 || out_ready;
	assign load      = in_valid && in_ready;
	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	always_comb begin
		e_started = in_restart ? 1'b0 : started_q;
		e_start   = in_restart ? '0 : start_q;
		e_last    = in_restart ? '0 : last_q;
		e_total   = in_restart ? '0 : total_q;
		e_carried = in_restart ? '0 : carried_q;

		wrap      = 1'b0;
		keep      = 1'b0;
		st0       = e_start;
		n_start   = e_start;
		n_carried = e_carried;
		n_last    = e_last;
		base      = e_total;

		if (cfg.mode == MODE_DOWN) begin
			// a timestamp going backwards restarts the timing
			wrap      = e_last > in_now;
			keep      = e_started && !wrap;
			n_start   = keep ? e_start : in_now;
			n_carried = keep ? e_carried : (wrap ? e_total : '0);
			base      = (keep || wrap) ? e_total : '0;
			n_last    = in_now;
		end else begin
			st0       = e_started ? e_start : in_now;
			wrap      = st0 > in_now;
			n_start   = wrap ? in_now : st0;
			n_carried = wrap ? e_total + 32'(e_total != '0) : e_carried;
		end

		elapsed = in_now - n_start;
		q_ms    = recip_div(elapsed, REC_MS, SH_MS);
		n_total = (cfg.mode == MODE_DOWN) ? base + 32'd1 : q_ms + n_carried;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			start_q   <= '0;
			last_q    <= '0;
			total_q   <= '0;
			carried_q <= '0;
			valid_s2  <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (load) begin
				started_q <= 1'b1;
				start_q   <= n_start;
				last_q    <= n_last;
				total_q   <= n_total;
				carried_q <= n_carried;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2.restart <= in_restart;
			item_s2.elapsed <= elapsed;
			item_s2.q_ms    <= q_ms;
			item_s2.carried <= n_carried;
		end
	end

endmodule

FILE: hw/rtl/ectc_split.sv
// Seconds stage and divider stage: resolves the second count for either mode,
// then divides it by minute, hour, day and year lengths. Depends on ectc_pkg.
module ectc_split (
	input  logic             clk,
	input  logic             arst_n,
	input  ectc_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  ectc_pkg::stamp_t in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output ectc_pkg::split_t out_item
);
	import ectc_pkg::*;

	typedef struct packed {
		logic        restart;
		logic        hit;
		logic [31:0] secs;
		logic [31:0] elapsed;
	} secs_t;

	logic   valid_s3, valid_s4;
	secs_t  item_s3;
	split_t item_s4;
	logic   ready_s3, load_s3, load_s4;

	logic [9:0]  rem_ms;
	logic        in_range;
	logic [31:0] left_secs, secs;
	logic        hit;

	assign in_ready  = !valid_s3 || ready_s3;
	assign load_s3   = in_valid && in_ready;
	assign ready_s3  = !valid_s4 || out_ready;
	assign load_s4   = valid_s3 && ready_s3;
	assign out_valid = valid_s4;
	assign out_item  = item_s4;

	// count-down: the target is a whole number of seconds, so rounding the remaining
	// ms half up only depends on the sub-second part of the elapsed time
	always_comb begin
		rem_ms    = 10'(in_item.elapsed - 32'(in_item.q_ms * MS_PER_SEC));
		in_range  = (in_item.q_ms < cfg.cd_secs) ||
			((in_item.q_ms == cfg.cd_secs) && (rem_ms == '0));
		left_secs = in_range ?
			cfg.cd_secs - in_item.q_ms - 32'(rem_ms > 10'(HALF_SEC_MS)) : '0;
		if (cfg.mode == MODE_DOWN) begin
			secs = left_secs - in_item.carried;
			hit  = (secs == '0) || ({10'd0, secs} > cfg.target_ms);
		end else begin
			secs = in_item.q_ms + in_item.carried;
			hit  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (ready_s3) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			item_s3.restart <= in_item.restart;
			item_s3.hit     <= hit;
			item_s3.secs    <= secs;
			item_s3.elapsed <= in_item.elapsed;
		end
		if (load_s4) begin
			item_s4.restart <= item_s3.restart;
			item_s4.hit     <= item_s3.hit;
			item_s4.secs    <= item_s3.secs;
			item_s4.q_min   <= recip_div(item_s3.secs, REC_MIN, SH_MIN);
			item_s4.q_hour  <= recip_div(item_s3.secs, REC_HOUR, SH_HOUR);
			item_s4.q_day   <= recip_div(item_s3.secs, REC_DAY, SH_DAY);
			item_s4.q_year  <= 8'(recip_div(item_s3.secs, REC_YEAR, SH_YEAR));
			item_s4.elapsed <= item_s3.elapsed;
		end
	end

endmodule

FILE: hw/rtl/ectc_cal.sv
// Calendar stage and result register: time fields, day/month/year stepping,
// count-down done flag. Depends on ectc_pkg.
module ectc_cal (
	input  logic              clk,
	input  logic              arst_n,
	input  ectc_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  ectc_pkg::split_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output ectc_pkg::result_t out_item
);
	import ectc_pkg::*;

	logic       armed_q, short_q, done_q;
	logic [8:0] day_q;
	logic [3:0] month_q;
	logic [7:0] year_q;
	logic       res_valid_q;
	result_t    res_q;

	logic       e_armed, e_short, e_done;
	logic [8:0] e_day;
	logic [3:0] e_month;
	logic [7:0] e_year;
	logic       n_armed, n_short, n_done;
	logic [8:0] n_day;
	logic [3:0] n_month;
	logic [7:0] n_year;
	logic [5:0] f_sec, f_min;
	logic [4:0] f_hour;
	logic [8:0] f_yday;
	result_t    res;
	logic       load;

	assign in_ready  = !res_valid_q || out_ready;
	assign load      = in_valid && in_ready;
	assign out_valid = res_valid_q;
	assign out_item  = res_q;

	always_comb begin
		f_sec  = 6'(in_item.secs - 32'(in_item.q_min * SECS_PER_MIN));
		f_min  = 6'(in_item.q_min - 32'(in_item.q_hour * MIN_PER_HOUR));
		f_hour = 5'(in_item.q_hour - 32'(in_item.q_day * HOURS_PER_DAY));
		f_yday = 9'(in_item.q_day - 32'({24'd0, in_item.q_year} * DAYS_PER_YEAR));

		e_armed = in_item.restart ? 1'b0 : armed_q;
		e_short = in_item.restart ? 1'b1 : short_q;
		e_done  = in_item.restart ? 1'b0 : done_q;
		e_day   = in_item.restart ? '0 : day_q;
		e_month = in_item.restart ? '0 : month_q;
		e_year  = in_item.restart ? '0 : year_q;

		n_armed = e_armed;
		n_short = e_short;
		n_done  = e_done;
		n_day   = e_day;
		n_month = e_month;
		n_year  = e_year;

		res.sec_field  = f_sec;
		res.min_field  = f_min;
		res.hour_field = f_hour;
		res.whole_days = 16'(in_item.q_day);

		if (cfg.mode == MODE_DOWN) begin
			n_done = e_done || in_item.hit;
			if (n_done) begin
				n_day          = '0;
				n_year         = '0;
				res.sec_field  = '0;
				res.min_field  = '0;
				res.hour_field = '0;
				res.whole_days = '0;
			end else begin
				n_day  = f_yday;
				n_year = in_item.q_year;
			end
		end else begin
			// arm in the afternoon, count the day once the hour falls back to noon or earlier
			if (f_hour >= DAY_ARM_HOUR) begin
				n_armed = 1'b1;
			end else if (e_armed) begin
				n_day   = e_day + 9'd1;
				n_armed = 1'b0;
			end
			if (e_month >= MONTH_LAST && n_day >= SHORT_MONTH_DAYS) begin
				n_short = 1'b1;
				n_day   = '0;
				n_month = '0;
				n_year  = e_year + 8'd1;
			end else if (n_day >= SHORT_MONTH_DAYS && e_short) begin
				n_short = 1'b0;
				n_day   = '0;
				n_month = e_month + 4'd1;
			end else if (n_day >= LONG_MONTH_DAYS && !e_short) begin
				n_short = 1'b1;
				n_day   = '0;
				n_month = e_month + 4'd1;
			end
		end

		res.day_field   = n_day;
		res.month_field = n_month;
		res.year_field  = n_year;
		res.elapsed_ms  = in_item.elapsed;
		res.done_flag   = n_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			short_q     <= 1'b1;
			done_q      <= 1'b0;
			day_q       <= '0;
			month_q     <= '0;
			year_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				res_valid_q <= in_valid;
			end
			if (load) begin
				armed_q <= n_armed;
				short_q <= n_short;
				done_q  <= n_done;
				day_q   <= n_day;
				month_q <= n_month;
				year_q  <= n_year;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

FILE: hw/rtl/elapsed_and_countdown_time_counter.sv
// Top level of the elapsed / count-down time counter: configuration registers,
// input register and the stage chain. Depends on ectc_pkg, ectc_stamp, ectc_split, ectc_cal.
//
//  channel   dir  handshake         payload
//  s_*       in   s_tvalid/tready   tdata: now_ms; tuser: restart
//  m_*       out  m_tvalid/tready   tdata: time fields, elapsed_ms; tuser: done_flag
//  cfg_*     in   cfg_we            cfg_index, cfg_wdata
//
// One beat per cycle in each direction while m_tready is high; a result passes in turn through
// the input register, stamp, seconds, divider and calendar/result stages.
// The stamp stage holds the loop that carries seconds from one beat to the next.
// Stages fill when empty, so input beats are taken while a result stalls, until all are full.
// Reset clears the counter state and the configuration; no warm-up is needed.
module elapsed_and_countdown_time_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] now_ms
	input  logic [0:0]  s_tuser,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [5:0] sec_field, [11:6] min_field, [16:12] hour_field,
	                               // [25:17] day_field, [29:26] month_field,
	                               // [37:30] year_field, [53:38] whole_days,
	                               // [85:54] elapsed_ms, [87:86] zero
	output logic [0:0]  m_tuser,   // [0] done_flag
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import ectc_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [31:0] now_s1;
	logic        restart_s1;

	logic    stamp_ready, stamp_valid;
	stamp_t  stamp_item;
	logic    split_ready, split_valid;
	split_t  split_item;
	logic    cal_ready;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_UP;
			cfg_q.cd_secs   <= '0;
			cfg_q.target_ms <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_COUNT_MODE: begin
					cfg_q.mode <= count_mode_t'(cfg_wdata[0]);
				end
				REG_COUNTDOWN_SECONDS: begin
					cfg_q.cd_secs   <= cfg_wdata;
					cfg_q.target_ms <= {10'd0, cfg_wdata} * TARGET_W'(MS_PER_SEC);
				end
				default: begin
				end
			endcase
		end
	end

	assign s_tready = !valid_s1 || stamp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1     <= s_tdata;
			restart_s1 <= s_tuser[0];
		end
	end

	ectc_stamp u_stamp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (valid_s1),
		.in_ready   (stamp_ready),
		.in_now     (now_s1),
		.in_restart (restart_s1),
		.out_valid  (stamp_valid),
		.out_ready  (split_ready),
		.out_item   (stamp_item)
	);

	ectc_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (stamp_valid),
		.in_ready  (split_ready),
		.in_item   (stamp_item),
		.out_valid (split_valid),
		.out_ready (cal_ready),
		.out_item  (split_item)
	);

	ectc_cal u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (split_valid),
		.in_ready  (cal_ready),
		.in_item   (split_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (res)
	);

	assign m_tdata = {2'b00, res.elapsed_ms, res.whole_days, res.year_field,
		res.month_field, res.day_field, res.hour_field, res.min_field, res.sec_field};
	assign m_tuser = res.done_flag;

endmodule

FILE: hw/rtl/ectc_checker.sv
// Port-level checks for the elapsed / count-down time counter, bound to the top level.
// Depends on elapsed_and_countdown_time_counter port names only.
module ectc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [0:0]  m_tuser
);
	localparam logic [2:0] PIPE_DEPTH = 3'd5;

	logic [2:0] inflight_q;
	logic       in_beat, out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> !m_tvalid)
		else $error("result beat without an input beat in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= PIPE_DEPTH)
		else $error("more beats in flight than pipeline slots");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> s_tready)
		else $error("input stalled with an empty pipeline");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] < 6'd60) && (m_tdata[11:6] < 6'd60) &&
			(m_tdata[16:12] < 5'd24) && (m_tdata[25:17] < 9'd365) &&
			(m_tdata[29:26] < 4'd12))
		else $error("time field out of range");

endmodule

bind elapsed_and_countdown_time_counter ectc_checker u_checker (.*);
